// ===== rtl/core/u8vd_pkg.sv =====
// Shared constants, types and helper functions for the UTF-8 validating decoder.
// No dependencies; compile first.
`default_nettype none

package u8vd_pkg;

  // Longest string the offset counter has to cover; offsets saturate below it.
  localparam longint unsigned MAX_STRING_BYTES = 65536;
  localparam int unsigned     OFFS_W           = 16;
  localparam int unsigned     CODE_W           = 21;

  localparam logic [OFFS_W-1:0] OFFS_LIMIT =
    ((MAX_STRING_BYTES - 1) > 64'hFFFF) ? {OFFS_W{1'b1}}
                                         : OFFS_W'(MAX_STRING_BYTES - 1);

  // Largest Unicode scalar value and the surrogate range
  localparam logic [CODE_W-1:0] CODE_MAX       = 21'h10FFFF;
  localparam logic [CODE_W-1:0] SURROGATE_LO   = 21'h00D800;
  localparam logic [CODE_W-1:0] SURROGATE_HI   = 21'h00DFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_BAD_CONT  = 2'd2,
    ST_TRUNCATED = 2'd3
  } u8vd_status_t;

  // Number of continuation bytes after a valid lead; 0 for anything else.
  function automatic logic [1:0] seq_extra(input logic [7:0] lead);
    logic [1:0] n;
    n = 2'd0;
    if (lead inside {[8'hC2:8'hDF]}) n = 2'd1;
    else if (lead inside {[8'hE0:8'hEF]}) n = 2'd2;
    else if (lead inside {[8'hF0:8'hF4]}) n = 2'd3;
    return n;
  endfunction

  // Range check on the first continuation byte, which depends on the lead.
  function automatic logic first_cont_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    case (lead)
      8'hE0:   ok = b inside {[8'hA0:8'hBF]};
      8'hED:   ok = b inside {[8'h80:8'h9F]};
      8'hF0:   ok = b inside {[8'h90:8'hBF]};
      8'hF4:   ok = b inside {[8'h80:8'h8F]};
      default: ok = b inside {[8'h80:8'hBF]};
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/u8vd_in_if.sv =====
// Byte input channel of the UTF-8 validating decoder: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface u8vd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_in_string;

  modport source (output valid, output byte_value, output last_in_string, input ready);
  modport sink   (input valid, input byte_value, input last_in_string, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u8vd_out_if.sv =====
// Result channel of the UTF-8 validating decoder: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface u8vd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic [15:0] error_offset;
  logic        end_of_string;

  modport source (output valid, output code_point, output status, output error_offset,
                  output end_of_string, input ready);
  modport sink   (input valid, input code_point, input status, input error_offset,
                  input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/utf8_validating_decoder_top.sv =====
// UTF-8 validating decoder, top level.
// Depends on u8vd_pkg, u8vd_in_if and u8vd_out_if.
//
// Usage:
//   in_ch carries one byte of text per transfer, with last_in_string set on
//   the final byte of a string. out_ch carries zero or one result per byte:
//   a decoded code point (status ok) when a sequence completes, or the first
//   error of the string (bad lead, bad continuation, truncated sequence)
//   with its byte offset. After an error the rest of the string is dropped
//   silently; end_of_string marks the last result of a string.
//   Path: a byte taken from in_ch lands in the input register; its result
//   is loaded into the result register once that register is free, and
//   out_ch.valid is driven from the result register.
//   Throughput: one byte per cycle while out_ch.ready stays high; the only
//   work per byte is a small state update between the two registers.
//   Receiver stall: the result register holds its item; the input register
//   holds one more byte, and in_ch.ready falls once both are full.
//   Reset (rst_n low, synchronous): both registers empty and the decoder
//   state is cleared, so the next byte starts a new string at offset 0.
`default_nettype none

module utf8_validating_decoder_top (
  input wire logic   clk,
  input wire logic   rst_n,
  u8vd_in_if.sink    in_ch,
  u8vd_out_if.source out_ch
);
  import u8vd_pkg::*;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Result register
  logic                out_valid_r;
  logic [CODE_W-1:0]   out_cp_r;
  u8vd_status_t        out_status_r;
  logic [OFFS_W-1:0]   out_off_r;
  logic                out_eos_r;

  // Decoder state
  logic [1:0]        bse_r,      bse_nxt;       // bytes still expected
  logic [7:0]        lead_r,     lead_nxt;
  logic [CODE_W-1:0] part_r,     part_nxt;
  logic              errp_r,     errp_nxt;
  logic [OFFS_W-1:0] perr_off_r, perr_off_nxt;
  logic [OFFS_W-1:0] lead_off_r, lead_off_nxt;
  logic [OFFS_W-1:0] pos_r,      pos_nxt;
  logic              skip_r,     skip_nxt;

  // Result of the current byte
  logic              emit;
  logic [CODE_W-1:0] res_cp;
  u8vd_status_t      res_status;
  logic [OFFS_W-1:0] res_off;
  logic              res_eos;

  logic              res_free;   // result register can take a new item
  logic              fire;       // input register item is processed this cycle

  // Scratch for the per-byte update
  logic [1:0]        n_lead;
  logic              first_pos;
  logic              cont_ok;
  logic [CODE_W-1:0] part_shift;
  logic [1:0]        bse_dec;
  logic              err_now;
  logic              clear_now;

  assign res_free    = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && res_free;
  assign in_ch.ready = !s1_valid_r || res_free;

  // Input register: advance whenever it is empty or its item is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.byte_value;
      s1_last_r <= in_ch.last_in_string;
    end
  end

  // Per-byte decode and state update
  always_comb begin
    bse_nxt      = bse_r;
    lead_nxt     = lead_r;
    part_nxt     = part_r;
    errp_nxt     = errp_r;
    perr_off_nxt = perr_off_r;
    lead_off_nxt = lead_off_r;
    skip_nxt     = skip_r;
    pos_nxt      = (pos_r < OFFS_LIMIT) ? pos_r + OFFS_W'(1) : OFFS_LIMIT;

    emit       = 1'b0;
    res_cp     = '0;
    res_status = ST_OK;
    res_off    = '0;
    res_eos    = s1_last_r;
    err_now    = 1'b0;
    clear_now  = 1'b0;

    n_lead     = seq_extra(s1_byte_r);
    first_pos  = (bse_r == seq_extra(lead_r));
    cont_ok    = first_pos ? first_cont_ok(lead_r, s1_byte_r)
                           : (s1_byte_r inside {[8'h80:8'hBF]});
    part_shift = {part_r[CODE_W-7:0], s1_byte_r[5:0]};
    bse_dec    = bse_r - 2'd1;

    if (skip_r) begin
      // drop bytes until the string ends
      clear_now = s1_last_r;
    end else if (bse_r == 2'd0) begin
      if (!s1_byte_r[7]) begin
        emit      = 1'b1;
        res_cp    = CODE_W'(s1_byte_r);
        clear_now = s1_last_r;
      end else if (n_lead == 2'd0) begin
        err_now    = 1'b1;
        res_status = ST_BAD_LEAD;
        res_off    = pos_r;
      end else if (s1_last_r) begin
        err_now    = 1'b1;
        res_status = ST_TRUNCATED;
        res_off    = pos_r;
      end else begin
        lead_nxt     = s1_byte_r;
        bse_nxt      = n_lead;
        case (n_lead)
          2'd1:    part_nxt = CODE_W'(s1_byte_r[4:0]);
          2'd2:    part_nxt = CODE_W'(s1_byte_r[3:0]);
          default: part_nxt = CODE_W'(s1_byte_r[2:0]);
        endcase
        lead_off_nxt = pos_r;
        errp_nxt     = 1'b0;
        perr_off_nxt = '0;
      end
    end else begin
      // continuation position: hold the first bad byte's offset
      if (!cont_ok && !errp_r) begin
        errp_nxt     = 1'b1;
        perr_off_nxt = pos_r;
      end
      part_nxt = part_shift;
      bse_nxt  = bse_dec;
      if (bse_dec == 2'd0) begin
        if (errp_nxt) begin
          err_now    = 1'b1;
          res_status = ST_BAD_CONT;
          res_off    = perr_off_nxt;
        end else begin
          emit      = 1'b1;
          res_cp    = part_shift;
          part_nxt  = '0;
          clear_now = s1_last_r;
        end
      end else if (s1_last_r) begin
        err_now    = 1'b1;
        res_status = ST_TRUNCATED;
        res_off    = lead_off_r;
      end
    end

    if (err_now) begin
      emit    = 1'b1;
      res_cp  = '0;
      res_eos = 1'b1;
      if (s1_last_r) begin
        clear_now = 1'b1;
      end else begin
        bse_nxt  = 2'd0;
        errp_nxt = 1'b0;
        skip_nxt = 1'b1;
      end
    end

    // last byte of a string clears everything for the next string
    if (clear_now) begin
      bse_nxt      = 2'd0;
      lead_nxt     = '0;
      part_nxt     = '0;
      errp_nxt     = 1'b0;
      perr_off_nxt = '0;
      lead_off_nxt = '0;
      pos_nxt      = '0;
      skip_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bse_r      <= 2'd0;
      lead_r     <= '0;
      part_r     <= '0;
      errp_r     <= 1'b0;
      perr_off_r <= '0;
      lead_off_r <= '0;
      pos_r      <= '0;
      skip_r     <= 1'b0;
    end else if (fire) begin
      bse_r      <= bse_nxt;
      lead_r     <= lead_nxt;
      part_r     <= part_nxt;
      errp_r     <= errp_nxt;
      perr_off_r <= perr_off_nxt;
      lead_off_r <= lead_off_nxt;
      pos_r      <= pos_nxt;
      skip_r     <= skip_nxt;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_cp_r     <= res_cp;
      out_status_r <= res_status;
      out_off_r    <= res_off;
      out_eos_r    <= res_eos;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.code_point    = out_cp_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.error_offset  = out_off_r;
  assign out_ch.end_of_string = out_eos_r;

endmodule

`default_nettype wire

// ===== rtl/core/u8vd_checker.sv =====
// Port-level checks for the UTF-8 validating decoder, bound to its top level.
// Depends on u8vd_pkg and utf8_validating_decoder_top.
`default_nettype none

module u8vd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [20:0] out_code_point,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_error_offset,
  input wire logic        out_end_of_string
);
  import u8vd_pkg::*;

  // reset empties the result register
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays offered
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a good result is a scalar value with no error offset
  a_ok_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |->
      (out_code_point <= CODE_MAX) && (out_error_offset == '0) &&
      !((out_code_point >= SURROGATE_LO) && (out_code_point <= SURROGATE_HI)))
    else $error("bad code point or offset on good result");

  // an error ends the string's results and carries no code point
  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_end_of_string && (out_code_point == '0))
    else $error("error result without end of string");

endmodule

bind utf8_validating_decoder_top u8vd_checker u_u8vd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_code_point    (out_ch.code_point),
  .out_status        (out_ch.status),
  .out_error_offset  (out_ch.error_offset),
  .out_end_of_string (out_ch.end_of_string)
);

`default_nettype wire
